@@ rtl/core/kct_pkg.sv @@
package kct_pkg;

	localparam int KEY_W = 32;
	localparam int QTY_W = 32;

	// request opcodes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_UPDATE = 2'd2,
		OP_DUMP   = 2'd3
	} kct_op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_EMPTY   = 3'd4
	} kct_status_t;

	// one table record as it travels round the ring
	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] qty;
	} kct_entry_t;

	// final result of a lookup or insert pass
	typedef struct packed {
		kct_status_t      status;
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] qty;
	} kct_result_t;

endpackage

@@ rtl/core/keyed_count_table_sorted_dump_core.sv @@
// channel | signals                                   | direction
// request | in_valid, in_stall, opcode/part_key/amount | into block
// result  | out_valid, out_stall, status/out_key/      | out of block
//         |   out_quantity/last                        |
//
// every request rotates the record ring once, in TABLE_DEPTH steps after the
// accept; a new request is taken only once the pass has ended.
// the ring is kept in ascending key order; one unit at the ring tail does
// the match, sorted insert and add, so the ring length sets the rate.
// a step with a result to send waits while the result register is stalled.
// reset clears the occupancy flags and the record count; no clearing pass.
module keyed_count_table_sorted_dump_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] part_key,
	input  logic signed [31:0] amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] out_key,
	output logic signed [31:0] out_quantity,
	output logic               last
);
	import kct_pkg::*;

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic              dump_q;
	logic              ins_q;

	logic              out_valid_q;
	kct_status_t       status_q;
	logic [KEY_W-1:0]  key_q;
	logic [QTY_W-1:0]  qty_q;
	logic              last_q;

	logic              accept;
	logic              run;
	logic              last_step;
	logic              is_empty;
	logic              dump_rec;
	logic              dump_last;
	logic              emit;
	logic              slot_free;
	logic              adv;
	kct_entry_t        chain [TABLE_DEPTH];
	kct_entry_t        head;
	kct_entry_t        tail;
	kct_result_t       res;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign run       = (state_q == S_RUN);
	assign last_step = (step_q == STEP_W'(TABLE_DEPTH - 1));
	assign is_empty  = (entry_count_q == '0);
	assign head      = chain[0];
	assign dump_rec  = dump_q && head.vld;
	assign dump_last = ((CNT_W'(step_q) + CNT_W'(1)) == entry_count_q);
	assign emit      = run && (dump_rec || (last_step && !(dump_q && !is_empty)));
	assign slot_free = !out_valid_q || !out_stall;
	assign adv       = run && (!emit || slot_free);

	// record ring: cell i takes from cell i+1, the last cell from the tail unit
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == TABLE_DEPTH - 1) begin : g_end
			kct_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (adv),
				.nxt    (tail),
				.cur    (chain[i])
			);
		end else begin : g_mid
			kct_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (adv),
				.nxt    (chain[i+1]),
				.cur    (chain[i])
			);
		end
	end

	// match, insert and add unit at the ring tail
	kct_proc u_proc (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.adv      (adv),
		.opcode   (opcode),
		.part_key (part_key),
		.amount   (amount),
		.full     (entry_count_q == CNT_W'(TABLE_DEPTH)),
		.head     (head),
		.tail     (tail),
		.res      (res)
	);

	// sequencer and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			dump_q  <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						step_q  <= '0;
						dump_q  <= (kct_op_t'(opcode) == OP_DUMP);
						ins_q   <= (kct_op_t'(opcode) == OP_INSERT);
					end
				end
				S_RUN: begin
					if (adv) begin
						if (last_step) begin
							state_q <= S_IDLE;
							step_q  <= '0;
						end else begin
							step_q <= step_q + STEP_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (adv && last_step && ins_q && res.status == ST_OK) begin
			entry_count_q <= entry_count_q + CNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			if (dump_rec) begin
				status_q <= ST_OK;
				key_q    <= head.key;
				qty_q    <= head.qty;
				last_q   <= dump_last;
			end else begin
				status_q <= res.status;
				key_q    <= res.key;
				qty_q    <= res.qty;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_key      = key_q;
	assign out_quantity = qty_q;
	assign last         = last_q;

	// record count stays within the ring
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(TABLE_DEPTH))
		else $error("record count beyond table depth");

	// count moves only at the end of a successful insert pass
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !(last_step && ins_q) |=> $stable(entry_count_q))
		else $error("record count changed outside an insert");

	// occupied records form a prefix of the ring as it streams past the head
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> (head.vld == (CNT_W'(step_q) < entry_count_q)))
		else $error("occupied records not a contiguous prefix");

	// a dump transfer that closes the stream marks the last record
	a_dump_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && dump_rec && last_step |-> dump_last)
		else $error("full-table dump missed its last flag");

endmodule

@@ rtl/core/kct_cell.sv @@
module kct_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  kct_pkg::kct_entry_t nxt,
	output kct_pkg::kct_entry_t cur
);
	import kct_pkg::*;

	logic             vld_q;
	logic [KEY_W-1:0] key_q;
	logic [QTY_W-1:0] qty_q;

	// occupancy flag, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= nxt.vld;
		end
	end

	// record payload, taken from the neighbour on each ring step
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= nxt.key;
			qty_q <= nxt.qty;
		end
	end

	assign cur = '{vld: vld_q, key: key_q, qty: qty_q};

endmodule

@@ rtl/core/kct_proc.sv @@
module kct_proc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                adv,
	input  logic [1:0]          opcode,
	input  logic [31:0]         part_key,
	input  logic [31:0]         amount,
	input  logic                full,
	input  kct_pkg::kct_entry_t head,
	output kct_pkg::kct_entry_t tail,
	output kct_pkg::kct_result_t res
);
	import kct_pkg::*;

	kct_op_t          op_q;
	logic [KEY_W-1:0] key_q;
	logic [QTY_W-1:0] amt_q;
	logic             full_q;
	logic             hit_q;
	logic [QTY_W-1:0] res_qty_q;
	logic             pend_vld_q;
	logic [KEY_W-1:0] pend_key_q;
	logic [QTY_W-1:0] pend_qty_q;

	kct_entry_t       pend;
	logic             match;
	logic             lookup;
	logic             goes_before;
	logic [QTY_W-1:0] new_qty;
	logic             hit_now;

	assign pend        = '{vld: pend_vld_q, key: pend_key_q, qty: pend_qty_q};
	assign match       = head.vld && (head.key == key_q);
	assign lookup      = (op_q == OP_SEARCH) || (op_q == OP_UPDATE);
	assign goes_before = !head.vld || ($signed(key_q) < $signed(head.key));
	assign new_qty     = (op_q == OP_UPDATE) ? head.qty + amt_q : head.qty;

	// record written back at the tail of the ring for this step
	always_comb begin
		tail = head;
		case (op_q) inside
			OP_INSERT: begin
				if (pend_vld_q && !match && goes_before) begin
					tail = pend;
				end
			end
			OP_SEARCH, OP_UPDATE: begin
				if (match) begin
					tail.qty = new_qty;
				end
			end
			default: begin
				tail = head;
			end
		endcase
	end

	// request context and per-pass flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (start) begin
			hit_q      <= 1'b0;
			pend_vld_q <= (kct_op_t'(opcode) == OP_INSERT) && !full;
		end else if (adv) begin
			if (op_q == OP_INSERT && pend_vld_q) begin
				if (match) begin
					hit_q      <= 1'b1;
					pend_vld_q <= 1'b0;
				end else if (goes_before) begin
					pend_vld_q <= head.vld;
				end
			end else if (lookup && match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q       <= kct_op_t'(opcode);
			key_q      <= part_key;
			amt_q      <= amount;
			full_q     <= full;
			pend_key_q <= part_key;
			pend_qty_q <= amount;
		end else if (adv) begin
			if (op_q == OP_INSERT && pend_vld_q && !match && goes_before) begin
				pend_key_q <= head.key;
				pend_qty_q <= head.qty;
			end
			if (lookup && match) begin
				res_qty_q <= new_qty;
			end
		end
	end

	// final status, valid on the last ring step
	assign hit_now = hit_q || (match && (lookup || pend_vld_q));

	always_comb begin
		res = '{status: ST_OK, key: key_q, qty: '0};
		case (op_q) inside
			OP_INSERT: begin
				if (full_q) begin
					res.status = ST_FULL;
				end else if (hit_now) begin
					res.status = ST_DUP;
				end else begin
					res.qty = amt_q;
				end
			end
			OP_SEARCH, OP_UPDATE: begin
				if (hit_now) begin
					res.qty = match ? new_qty : res_qty_q;
				end else begin
					res.status = ST_MISSING;
				end
			end
			default: begin
				res = '{status: ST_EMPTY, key: '0, qty: '0};
			end
		endcase
	end

endmodule

@@ test/keyed_count_table_sorted_dump_core_tb.sv @@
`timescale 1ns / 1ps

module keyed_count_table_sorted_dump_core_tb;
	import kct_pkg::*;

	localparam int DEPTH          = 64;
	localparam int DIR_ROWS       = 18;
	localparam int RANDOM_ITEMS   = 142;
	localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;
	localparam int WATCHDOG_LIMIT = 20000;

	// one row of the directed table; fixed_exp marks a typed-in result
	typedef struct packed {
		kct_op_t     op;
		logic [31:0] key;
		logic [31:0] amt;
		logic        fixed_exp;
		kct_status_t st;
		logic [31:0] ekey;
		logic [31:0] eqty;
	} dir_row_t;

	// one result as it should leave the block
	typedef struct packed {
		kct_status_t st;
		logic [31:0] key;
		logic [31:0] qty;
		logic        last;
	} table_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_INSERT;
	logic signed [31:0] part_key = '0;
	logic signed [31:0] amount = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] out_key;
	logic signed [31:0] out_quantity;
	logic               last;

	// shadow copy of the record table
	logic [31:0]   ledger_keys [DEPTH];
	logic [31:0]   ledger_qty [DEPTH];
	int            ledger_count = 0;
	table_result_t fresh_results [$];
	table_result_t awaited_results [$];
	table_result_t head_result;

	bit throttle_on = 1'b1;
	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int status_seen [5];
	int idle_run = 0;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{OP_DUMP,   32'h1234_5678, 32'h9abc_def0, 1'b1, ST_EMPTY,   32'h0, 32'h0},
		'{OP_SEARCH, 32'h0000_0005, 32'h0,         1'b1, ST_MISSING, 32'h5, 32'h0},
		'{OP_UPDATE, 32'hffff_fff9, 32'h3,         1'b1, ST_MISSING, 32'hffff_fff9, 32'h0},
		'{OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, ST_OK, 32'h7fff_ffff, 32'h7fff_ffff},
		'{OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1, ST_OK, 32'h8000_0000, 32'h8000_0000},
		'{OP_INSERT, 32'h0,         32'h0,         1'b1, ST_OK, 32'h0, 32'h0},
		'{OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_OK, 32'hffff_ffff, 32'hffff_ffff},
		'{OP_INSERT, 32'h1,         32'd100,       1'b1, ST_OK, 32'h1, 32'd100},
		'{OP_INSERT, 32'h7fff_ffff, 32'h5,         1'b1, ST_DUP, 32'h7fff_ffff, 32'h0},
		'{OP_SEARCH, 32'h8000_0000, 32'h0,         1'b1, ST_OK, 32'h8000_0000, 32'h8000_0000},
		'{OP_UPDATE, 32'h7fff_ffff, 32'h1,         1'b1, ST_OK, 32'h7fff_ffff, 32'h8000_0000},
		'{OP_UPDATE, 32'h8000_0000, 32'hffff_ffff, 1'b0, ST_OK, 32'h0, 32'h0},
		'{OP_DUMP,   32'h0,         32'h0,         1'b0, ST_OK, 32'h0, 32'h0},
		'{OP_SEARCH, 32'h2,         32'h0,         1'b1, ST_MISSING, 32'h2, 32'h0},
		'{OP_UPDATE, 32'hffff_ffff, 32'h7fff_ffff, 1'b0, ST_OK, 32'h0, 32'h0},
		'{OP_INSERT, 32'hffff_fffe, 32'h1234_5678, 1'b0, ST_OK, 32'h0, 32'h0},
		'{OP_DUMP,   32'hdead_beef, 32'h5555_aaaa, 1'b0, ST_OK, 32'h0, 32'h0},
		'{OP_SEARCH, 32'h1,         32'h0,         1'b0, ST_OK, 32'h0, 32'h0}
	};

	keyed_count_table_sorted_dump_core #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.part_key    (part_key),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_key     (out_key),
		.out_quantity(out_quantity),
		.last        (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// linear match over the stored records
	function automatic int find_key(input logic [31:0] key);
		for (int i = 0; i < ledger_count; i++)
			if (ledger_keys[i] == key)
				return i;
		return -1;
	endfunction

	// work out the results of one request and update the shadow table
	task automatic apply_request(input kct_op_t op, input logic [31:0] key,
	                             input logic [31:0] amt);
		int          idx;
		int          j;
		logic [31:0] k;
		logic [31:0] q;
		fresh_results.delete();
		case (op) inside
			OP_INSERT: begin
				if (ledger_count >= DEPTH)
					fresh_results.push_back('{ST_FULL, key, 32'h0, 1'b1});
				else if (find_key(key) >= 0)
					fresh_results.push_back('{ST_DUP, key, 32'h0, 1'b1});
				else begin
					ledger_keys[ledger_count] = key;
					ledger_qty[ledger_count] = amt;
					ledger_count++;
					fresh_results.push_back('{ST_OK, key, amt, 1'b1});
				end
			end
			OP_SEARCH, OP_UPDATE: begin
				idx = find_key(key);
				if (idx < 0)
					fresh_results.push_back('{ST_MISSING, key, 32'h0, 1'b1});
				else begin
					if (op == OP_UPDATE)
						ledger_qty[idx] = ledger_qty[idx] + amt;
					fresh_results.push_back('{ST_OK, key, ledger_qty[idx], 1'b1});
				end
			end
			default: begin
				if (ledger_count == 0)
					fresh_results.push_back('{ST_EMPTY, 32'h0, 32'h0, 1'b1});
				else begin
					// insertion sort on signed key order
					for (int i = 1; i < ledger_count; i++) begin
						k = ledger_keys[i];
						q = ledger_qty[i];
						j = i;
						while (j > 0 && $signed(k) < $signed(ledger_keys[j-1])) begin
							ledger_keys[j] = ledger_keys[j-1];
							ledger_qty[j] = ledger_qty[j-1];
							j--;
						end
						ledger_keys[j] = k;
						ledger_qty[j] = q;
					end
					for (int i = 0; i < ledger_count; i++)
						fresh_results.push_back('{ST_OK, ledger_keys[i], ledger_qty[i],
							i == ledger_count - 1});
				end
			end
		endcase
	endtask

	// present one request and hold it until the transfer
	task automatic send_request(input kct_op_t op, input logic [31:0] key,
	                            input logic [31:0] amt);
		while (throttle_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		part_key <= key;
		amount <= amt;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// key that is mostly new, sometimes clustered or at the extremes
	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom;
		if (r < 88)
			return 32'($urandom_range(40)) - 32'd20;
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] pick_amount();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom;
		if (r < 80)
			return 32'($urandom_range(200)) - 32'd100;
		case ($urandom_range(2))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// random request; early on inserts dominate so the table fills up
	task automatic pick_request(input int n, output kct_op_t op,
	                            output logic [31:0] key, output logic [31:0] amt);
		int r;
		int insert_weight;
		insert_weight = (n < 100) ? 65 : 20;
		r = $urandom_range(99);
		if (r < 6)
			op = OP_DUMP;
		else if (r < 6 + insert_weight)
			op = OP_INSERT;
		else if (r < 6 + insert_weight + (94 - insert_weight) / 2)
			op = OP_SEARCH;
		else
			op = OP_UPDATE;
		key = pick_key();
		amt = pick_amount();
		// hit a stored key for most lookups and for some inserts, to get duplicates
		if (ledger_count > 0 && ((op != OP_INSERT && $urandom_range(99) < 75) ||
		                         (op == OP_INSERT && $urandom_range(99) < 15)))
			key = ledger_keys[$urandom_range(ledger_count - 1)];
	endtask

	// result side: random stall and comparison with the oldest expectation
	always @(posedge clk) begin
		out_stall <= throttle_on && ($urandom_range(99) < 31);
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result with nothing expected: status %0d key %0h qty %0h last %0b",
					status, out_key, out_quantity, last);
				mismatches++;
			end else begin
				head_result = awaited_results.pop_front();
				results_checked++;
				if (status < 5)
					status_seen[status]++;
				if (status !== head_result.st) begin
					$error("status: expected %0d, got %0d", head_result.st, status);
					mismatches++;
				end
				if (out_key !== head_result.key) begin
					$error("out_key: expected %0h, got %0h", head_result.key, out_key);
					mismatches++;
				end
				if (out_quantity !== head_result.qty) begin
					$error("out_quantity: expected %0h, got %0h", head_result.qty,
						out_quantity);
					mismatches++;
				end
				if (last !== head_result.last) begin
					$error("last: expected %0b, got %0b", head_result.last, last);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("keyed_count_table_sorted_dump_core regression: fail");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		kct_op_t     op;
		logic [31:0] key;
		logic [31:0] amt;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].amt);
			apply_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].amt);
			if (directed_rows[i].fixed_exp)
				awaited_results.push_back('{directed_rows[i].st, directed_rows[i].ekey,
					directed_rows[i].eqty, 1'b1});
			else
				foreach (fresh_results[n])
					awaited_results.push_back(fresh_results[n]);
		end

		// random part, with a stretch of full-rate traffic in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			throttle_on = !(n >= 60 && n < 100);
			pick_request(n, op, key, amt);
			send_request(op, key, amt);
			apply_request(op, key, amt);
			foreach (fresh_results[m])
				awaited_results.push_back(fresh_results[m]);
		end
		in_valid <= 1'b0;
		throttle_on = 1'b1;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results checked, table holds %0d of %0d records",
			requests_sent, results_checked, ledger_count, DEPTH);
		$display("results seen: ok %0d, full %0d, duplicate %0d, not found %0d, empty %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
			status_seen[ST_MISSING], status_seen[ST_EMPTY]);
		if (mismatches == 0)
			$display("keyed_count_table_sorted_dump_core regression: pass");
		else
			$display("keyed_count_table_sorted_dump_core regression: fail");
		$finish;
	end

endmodule
